[src/gda_pkg.sv]
package gda_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int DELTA_W  = 17;
  localparam int WDAY_W   = 3;
  localparam int SERIAL_W = 22;
  localparam int STATUS_W = 2;
  localparam int REM_W    = 18;
  localparam int C400_W   = 9;
  localparam int MUL_W    = 23;
  localparam int PROD_W   = 46;

  localparam logic [SERIAL_W-1:0] SERIAL_MAX = 22'd3652059;
  localparam logic [MUL_W-1:0]    RECIP100   = 23'd5243;
  localparam logic [MUL_W-1:0]    RECIP7     = 23'd4793491;
  localparam logic [YEAR_W-1:0]   YEAR_MAX   = 14'd9999;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_Q1,
    S_Q2,
    S_CHK,
    S_WALK,
    S_WD1,
    S_WD2,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_Q1,
    OP_Q2,
    OP_CHK,
    OP_WALK,
    OP_WD1,
    OP_WD2
  } unit_op_t;

  typedef struct packed {
    unit_op_t op;
    logic     load_out;
    logic     idle;
  } ctl_t;

  typedef struct packed {
    logic bad_date;
    logic bad_range;
    logic walk_done;
  } flags_t;

  typedef struct packed {
    logic [DAY_W-1:0]    new_day;
    logic [MONTH_W-1:0]  new_month;
    logic [YEAR_W-1:0]   new_year;
    logic [WDAY_W-1:0]   weekday;
    logic [SERIAL_W-1:0] day_serial;
    logic [STATUS_W-1:0] status;
  } res_t;

  function automatic logic leap_of(input logic [C400_W-1:0] c);
    logic by100;
    by100 = (c == 9'd0) || (c == 9'd100) || (c == 9'd200) || (c == 9'd300);
    return ((c[1:0] == 2'd0) && !by100) || (c == 9'd0);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Days from 1 March to the first of the month, with January and February
  // counted at the end of the previous year.
  function automatic logic [8:0] month_off(input logic [MONTH_W-1:0] m);
    logic [8:0] off;
    case (m)
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

[src/gda_if.sv]
interface gda_in_if import gda_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [DAY_W-1:0]          day;
  logic [MONTH_W-1:0]        month;
  logic [YEAR_W-1:0]         year;
  logic signed [DELTA_W-1:0] delta_days;

  modport source (output valid, day, month, year, delta_days, input ready);
  modport sink (input valid, day, month, year, delta_days, output ready);
endinterface

interface gda_out_if import gda_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DAY_W-1:0]    new_day;
  logic [MONTH_W-1:0]  new_month;
  logic [YEAR_W-1:0]   new_year;
  logic [WDAY_W-1:0]   weekday;
  logic [SERIAL_W-1:0] day_serial;
  logic [STATUS_W-1:0] status;

  modport source (output valid, new_day, new_month, new_year, weekday, day_serial, status,
                  input ready);
  modport sink (input valid, new_day, new_month, new_year, weekday, day_serial, status,
                output ready);
endinterface

[src/gda_ctrl.sv]
module gda_ctrl import gda_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   out_busy,
  input  flags_t flags,
  output ctl_t   ctl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_Q1;
      end
      S_Q1:   state_nxt = S_Q2;
      S_Q2:   state_nxt = S_CHK;
      S_CHK: begin
        if (flags.bad_date || flags.bad_range) state_nxt = S_DONE;
        else state_nxt = S_WALK;
      end
      S_WALK: begin
        if (flags.walk_done) state_nxt = S_WD1;
      end
      S_WD1:  state_nxt = S_WD2;
      S_WD2:  state_nxt = S_DONE;
      S_DONE: begin
        if (!out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.op       = OP_NONE;
    ctl.load_out = 1'b0;
    ctl.idle     = 1'b0;
    case (state_r)
      S_IDLE: begin
        ctl.op   = OP_LOAD;
        ctl.idle = 1'b1;
      end
      S_Q1:   ctl.op = OP_Q1;
      S_Q2:   ctl.op = OP_Q2;
      S_CHK:  ctl.op = OP_CHK;
      S_WALK: ctl.op = OP_WALK;
      S_WD1:  ctl.op = OP_WD1;
      S_WD2:  ctl.op = OP_WD2;
      S_DONE: ctl.load_out = !out_busy;
      default: ctl.op = OP_NONE;
    endcase
  end

endmodule

[src/gda_unit.sv]
module gda_unit import gda_pkg::*; (
  input  logic                      clk,
  input  unit_op_t                  op,
  input  logic [DAY_W-1:0]          day,
  input  logic [MONTH_W-1:0]        month,
  input  logic [YEAR_W-1:0]         year,
  input  logic signed [DELTA_W-1:0] delta_days,
  output flags_t                    flags,
  output res_t                      res
);

  logic [DAY_W-1:0]    d_r, d_nxt;
  logic [MONTH_W-1:0]  m_r, m_nxt;
  logic [YEAR_W-1:0]   y_r, y_nxt;
  logic [REM_W-1:0]    r_r, r_nxt;
  logic [C400_W-1:0]   c400_r, c400_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [SERIAL_W-1:0] serial_r, serial_nxt;
  logic [WDAY_W-1:0]   wd_r, wd_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [7:0]        q100;
  logic [14:0]       y_rem;
  logic [YEAR_W-1:0] a_val;
  logic [25:0]       sn;
  logic              leap_cur;
  logic [DAY_W-1:0]  mlen_cur;
  logic [DAY_W-1:0]  room;
  logic [REM_W-1:0]  neg;
  logic [MUL_W-1:0]  s1;
  logic [MUL_W-1:0]  wd_full;
  logic              bad_date;
  logic              bad_range;

  assign q100     = prod_r[26:19];
  assign y_rem    = {1'b0, y_r} - 15'(q100[7:2]) * 15'd400;
  assign a_val    = (m_r < 4'd3) ? y_r - 14'd1 : y_r;
  assign leap_cur = leap_of(c400_r);
  assign mlen_cur = month_len(m_r, leap_cur);
  assign room     = mlen_cur - d_r;
  assign neg      = -r_r;
  assign s1       = {1'b0, serial_r} + 23'd1;
  assign wd_full  = s1 - 23'(prod_r[44:25]) * 23'd7;

  assign sn = 26'(a_val) * 26'd365 + 26'(a_val[13:2]) + 26'(q100[7:2])
              + 26'(month_off(m_r)) + 26'(d_r) - 26'(q100) - 26'd306
              + {{8{r_r[REM_W-1]}}, r_r};

  assign bad_date  = (m_r == 4'd0) || (m_r > 4'd12) || (d_r == 5'd0) || (d_r > mlen_cur)
                     || (y_r == 14'd0) || (y_r > YEAR_MAX);
  assign bad_range = sn[25] || (sn == 26'd0) || (sn > 26'(SERIAL_MAX));

  assign flags.bad_date  = bad_date;
  assign flags.bad_range = bad_range;
  assign flags.walk_done = (r_r == '0);

  always_comb begin
    d_nxt      = d_r;
    m_nxt      = m_r;
    y_nxt      = y_r;
    r_nxt      = r_r;
    c400_nxt   = c400_r;
    serial_nxt = serial_r;
    wd_nxt     = wd_r;
    status_nxt = status_r;
    mul_a      = '0;
    mul_b      = '0;
    case (op)
      OP_LOAD: begin
        d_nxt = day;
        m_nxt = month;
        y_nxt = year;
        r_nxt = {delta_days[DELTA_W-1], delta_days};
      end
      OP_Q1: begin
        mul_a = 23'(y_r);
        mul_b = RECIP100;
      end
      OP_Q2: begin
        c400_nxt = y_rem[8:0];
        mul_a    = 23'(a_val);
        mul_b    = RECIP100;
      end
      OP_CHK: begin
        serial_nxt = sn[SERIAL_W-1:0];
        if (bad_date) status_nxt = ST_BAD_DATE;
        else if (bad_range) status_nxt = ST_RANGE;
        else status_nxt = ST_OK;
      end
      OP_WALK: begin
        if (r_r == '0) begin
          r_nxt = r_r;
        end else if (!r_r[REM_W-1]) begin
          if (r_r <= 18'(room)) begin
            d_nxt = d_r + r_r[DAY_W-1:0];
            r_nxt = '0;
          end else begin
            r_nxt = r_r - 18'(room) - 18'd1;
            d_nxt = 5'd1;
            if (m_r == 4'd12) begin
              m_nxt    = 4'd1;
              y_nxt    = y_r + 14'd1;
              c400_nxt = (c400_r == 9'd399) ? 9'd0 : c400_r + 9'd1;
            end else begin
              m_nxt = m_r + 4'd1;
            end
          end
        end else begin
          if (neg < 18'(d_r)) begin
            d_nxt = d_r - neg[DAY_W-1:0];
            r_nxt = '0;
          end else begin
            r_nxt = r_r + 18'(d_r);
            if (m_r == 4'd1) begin
              m_nxt    = 4'd12;
              y_nxt    = y_r - 14'd1;
              c400_nxt = (c400_r == 9'd0) ? 9'd399 : c400_r - 9'd1;
              d_nxt    = 5'd31;
            end else begin
              m_nxt = m_r - 4'd1;
              d_nxt = month_len(m_r - 4'd1, leap_cur);
            end
          end
        end
      end
      OP_WD1: begin
        mul_a = s1;
        mul_b = RECIP7;
      end
      OP_WD2: begin
        wd_nxt = wd_full[WDAY_W-1:0];
      end
      default: begin
        d_nxt = d_r;
      end
    endcase
  end

  assign prod_nxt = 46'(mul_a) * 46'(mul_b);

  always_ff @(posedge clk) begin
    d_r      <= d_nxt;
    m_r      <= m_nxt;
    y_r      <= y_nxt;
    r_r      <= r_nxt;
    c400_r   <= c400_nxt;
    prod_r   <= prod_nxt;
    serial_r <= serial_nxt;
    wd_r     <= wd_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    res = '0;
    res.status = status_r;
    if (status_r == ST_OK) begin
      res.new_day    = d_r;
      res.new_month  = m_r;
      res.new_year   = y_r;
      res.weekday    = wd_r;
      res.day_serial = serial_r;
    end
  end

endmodule

[src/gregorian_date_add_days.sv]
// An accepted word goes through S_Q1, S_Q2, S_CHK, the month-by-month walk in
// S_WALK (one step per month boundary crossed, one for any final move inside a
// month), S_WD1, S_WD2 and S_DONE. An invalid date or an out-of-range result goes
// from S_CHK straight to S_DONE. The next word is taken in the cycle after its
// result is loaded into a free result register. Reset is synchronous and active
// low; it idles the sequencer and empties the result register.
module gregorian_date_add_days import gda_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  gda_in_if.sink    in_ch,
  gda_out_if.source out_ch
);

  ctl_t   ctl;
  flags_t flags;
  res_t   res;
  res_t   out_res_r;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_busy;

  assign out_busy = out_valid_r && !out_ch.ready;

  gda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_busy (out_busy),
    .flags    (flags),
    .ctl      (ctl)
  );

  gda_unit u_unit (
    .clk        (clk),
    .op         (ctl.op),
    .day        (in_ch.day),
    .month      (in_ch.month),
    .year       (in_ch.year),
    .delta_days (in_ch.delta_days),
    .flags      (flags),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load_out) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_res_r <= res;
    end
  end

  assign in_ch.ready       = ctl.idle;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.new_day    = out_res_r.new_day;
  assign out_ch.new_month  = out_res_r.new_month;
  assign out_ch.new_year   = out_res_r.new_year;
  assign out_ch.weekday    = out_res_r.weekday;
  assign out_ch.day_serial = out_res_r.day_serial;
  assign out_ch.status     = out_res_r.status;

endmodule

[src/gda_checker.sv]
module gda_checker import gda_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [DAY_W-1:0]    new_day,
  input logic [MONTH_W-1:0]  new_month,
  input logic [YEAR_W-1:0]   new_year,
  input logic [WDAY_W-1:0]   weekday,
  input logic [SERIAL_W-1:0] day_serial,
  input logic [STATUS_W-1:0] status
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(day_serial) && $stable(status))
    else $error("result word changed while stalled");

  // Error results carry zero in every date field.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> new_day == '0 && new_month == '0 && new_year == '0
      && weekday == '0 && day_serial == '0)
    else $error("error result with nonzero fields");

  // A good result is a real date with a weekday in range.
  a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_OK |-> new_month >= 4'd1 && new_month <= 4'd12
      && new_day >= 5'd1 && new_year >= 14'd1 && weekday <= 3'd6 && day_serial != '0)
    else $error("good result outside the calendar");

  // The block works on one word at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

endmodule

bind gregorian_date_add_days gda_checker u_gda_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .new_day    (out_ch.new_day),
  .new_month  (out_ch.new_month),
  .new_year   (out_ch.new_year),
  .weekday    (out_ch.weekday),
  .day_serial (out_ch.day_serial),
  .status     (out_ch.status)
);

[bench/tb_top.sv]
module tb_top import gda_pkg::*; ();

  typedef struct packed {
    logic [DAY_W-1:0]          day;
    logic [MONTH_W-1:0]        month;
    logic [YEAR_W-1:0]         year;
    logic signed [DELTA_W-1:0] delta;
  } date_req_t;

  localparam int RANDOM_WORDS = 246;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 600;

  class date_shift_board;
    res_t pending[$];
    int   errors;

    function bit leap_year(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int days_in(int y, int m);
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      if (m == 2) return leap_year(y) ? 29 : 28;
      return 31;
    endfunction

    function longint serial_of(int d, int m, int y);
      longint a;
      longint mm;
      a  = y;
      mm = m;
      if (mm < 3) begin
        a  = a - 1;
        mm = mm + 12;
      end
      return 365 * a + a / 4 - a / 100 + a / 400 + (153 * mm - 457) / 5 + d - 306;
    endfunction

    function int zeller_day(int d, int m, int y);
      int mm;
      int yy;
      int k;
      int j;
      mm = m;
      yy = y;
      if (mm < 3) begin
        mm = mm + 12;
        yy = yy - 1;
      end
      k = yy % 100;
      j = yy / 100;
      return (d + 13 * (mm + 1) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    endfunction

    function res_t shift_date(date_req_t w);
      res_t r;
      int d;
      int m;
      int y;
      longint dl;
      longint s;
      int unsigned z;
      int unsigned era;
      int unsigned doe;
      int unsigned yoe;
      int unsigned doy;
      int unsigned mp;
      int unsigned yy;
      int unsigned mo;
      int unsigned nd;
      r  = '0;
      d  = w.day;
      m  = w.month;
      y  = w.year;
      dl = longint'($signed(w.delta));
      if (m < 1 || m > 12 || y < 1 || y > 9999 || d < 1 || d > days_in(y, m)) begin
        r.status = ST_BAD_DATE;
        return r;
      end
      s = serial_of(d, m, y) + dl;
      if (s < 1 || s > longint'(SERIAL_MAX)) begin
        r.status = ST_RANGE;
        return r;
      end
      // Civil date from a day count that starts on 1 March of year 0.
      z   = int'(s) + 305;
      era = z / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      yy  = yoe + era * 400;
      mo  = (mp < 10) ? mp + 3 : mp - 9;
      nd  = doy - (153 * mp + 2) / 5 + 1;
      if (mo <= 2) yy = yy + 1;
      r.new_day    = nd[DAY_W-1:0];
      r.new_month  = mo[MONTH_W-1:0];
      r.new_year   = yy[YEAR_W-1:0];
      r.weekday    = WDAY_W'(zeller_day(nd, mo, yy));
      r.day_serial = SERIAL_W'(s);
      r.status     = ST_OK;
      return r;
    endfunction

    function void note_word(date_req_t w);
      pending.push_back(shift_date(w));
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: d=%0d m=%0d y=%0d wd=%0d serial=%0d st=%0d",
                   got.new_day, got.new_month, got.new_year, got.weekday,
                   got.day_serial, got.status);
        return;
      end
      want = pending.pop_front();
      if (got.new_day !== want.new_day || got.new_month !== want.new_month ||
          got.new_year !== want.new_year || got.weekday !== want.weekday ||
          got.day_serial !== want.day_serial || got.status !== want.status) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected d=%0d m=%0d y=%0d wd=%0d serial=%0d st=%0d",
                   want.new_day, want.new_month, want.new_year, want.weekday,
                   want.day_serial, want.status);
          $display("          got      d=%0d m=%0d y=%0d wd=%0d serial=%0d st=%0d",
                   got.new_day, got.new_month, got.new_year, got.weekday,
                   got.day_serial, got.status);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  gda_in_if  in_ch();
  gda_out_if out_ch();

  gregorian_date_add_days u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  date_shift_board board;
  int              words_sent;
  int              words_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic date_req_t make_req(int d, int m, int y, int dl);
    date_req_t r;
    r.day   = DAY_W'(d);
    r.month = MONTH_W'(m);
    r.year  = YEAR_W'(y);
    r.delta = DELTA_W'(dl);
    return r;
  endfunction

  function automatic date_req_t random_req();
    date_req_t r;
    int y;
    int m;
    int dl;
    int pick;
    if ($urandom_range(0, 99) < 15) begin
      r.day   = DAY_W'($urandom_range(0, 31));
      r.month = MONTH_W'($urandom_range(0, 15));
      r.year  = YEAR_W'($urandom_range(0, 16383));
      r.delta = DELTA_W'($urandom_range(0, 131071));
      return r;
    end
    pick = $urandom_range(0, 7);
    if (pick == 0) y = $urandom_range(1, 4);
    else if (pick == 1) y = $urandom_range(9996, 9999);
    else y = $urandom_range(1, 9999);
    m    = $urandom_range(1, 12);
    pick = $urandom_range(0, 19);
    if (pick < 2) dl = $urandom_range(0, 131071) - 65536;
    else if (pick < 6) dl = $urandom_range(0, 80) - 40;
    else dl = $urandom_range(0, 3000) - 1500;
    return make_req($urandom_range(1, board.days_in(y, m)), m, y, dl);
  endfunction

  task automatic send_word(input date_req_t w);
    int gap;
    gap = (words_sent >= 150 && words_sent < 200) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.day        <= w.day;
    in_ch.month      <= w.month;
    in_ch.year       <= w.year;
    in_ch.delta_days <= w.delta;
    do @(posedge clk); while (!in_ch.ready);
    board.note_word(w);
    words_sent++;
  endtask

  initial begin
    int stall;
    res_t got;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = (words_seen >= 140 && words_seen < 210) ? 0 : $urandom_range(0, 9);
      // A long hold-off lets the sender back up behind a full result register.
      if (words_seen == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = '{new_day: out_ch.new_day, new_month: out_ch.new_month,
              new_year: out_ch.new_year, weekday: out_ch.weekday,
              day_serial: out_ch.day_serial, status: out_ch.status};
      board.check_word(got);
      words_seen++;
    end
  end

  initial begin
    date_req_t directed[$];
    board      = new;
    words_sent = 0;
    words_seen = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.day        <= '0;
    in_ch.month      <= '0;
    in_ch.year       <= '0;
    in_ch.delta_days <= '0;

    directed.push_back(make_req(1, 1, 1, 0));
    directed.push_back(make_req(31, 12, 9999, 0));
    directed.push_back(make_req(1, 1, 1, -1));
    directed.push_back(make_req(31, 12, 9999, 1));
    directed.push_back(make_req(1, 1, 1, 65535));
    directed.push_back(make_req(31, 12, 9999, -65536));
    directed.push_back(make_req(15, 6, 5000, 65535));
    directed.push_back(make_req(15, 6, 5000, -65535));
    directed.push_back(make_req(29, 2, 2000, 0));
    directed.push_back(make_req(29, 2, 1900, 1));
    directed.push_back(make_req(29, 2, 2004, 365));
    directed.push_back(make_req(29, 2, 2001, 0));
    directed.push_back(make_req(0, 5, 2020, 3));
    directed.push_back(make_req(31, 4, 2020, 0));
    directed.push_back(make_req(10, 0, 2020, 0));
    directed.push_back(make_req(10, 13, 2020, 0));
    directed.push_back(make_req(31, 15, 16383, -1));
    directed.push_back(make_req(1, 1, 0, 10));
    directed.push_back(make_req(28, 2, 2023, 1));
    directed.push_back(make_req(31, 12, 1999, 1));
    directed.push_back(make_req(1, 3, 2000, -1));
    directed.push_back(make_req(1, 3, 1900, -1));
    directed.push_back(make_req(31, 1, 9999, 335));
    directed.push_back(make_req(2, 1, 1, -1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_word(directed[i]);
    repeat (RANDOM_WORDS) send_word(random_req());
    in_ch.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
